// ===== src/mpq_pkg.sv =====
// Multilevel priority queue: shared types and constants.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package mpq_pkg;

   localparam int LEVELS   = 8;
   localparam int LVL_W    = $clog2(LEVELS);
   localparam int STATUS_W = 2;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef logic [LEVELS-1:0] level_mask_type;

endpackage

// ===== src/mpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/multilevel_priority_queue_unit.sv =====
// Multilevel priority queue: one FIFO per level, nodes in a shared linked store.
// Uses mpq_pkg and mpq_ram (node values and node links).
//
// Channels: req_ carries one operation (enqueue or dequeue) per transfer,
// rsp_ returns exactly one result per operation, in order. Both use
// valid/stall; a transfer happens when valid is high and stall is low.
// csr_ writes highest_level (levels above it are neither scanned on dequeue
// nor counted in rsp_queue_empty); csr_ready is always high.
// Timing: an operation is taken in ST_IDLE, which also issues the node reads,
// and is finished in ST_FINISH, once the read data of the node RAMs has
// returned and the result register is loaded. The block takes no new
// request until the current operation has finished.
// The result register holds while rsp_stall is high; the block stays in its
// finishing cycle and keeps req_stall high until the register frees up.
// Reset: all queues empty, all CAPACITY nodes free, highest_level = 7. No
// clearing pass: unused nodes are handed out from a fresh counter until
// freed nodes are available on a recycle list.
`timescale 1ns / 1ps

module multilevel_priority_queue_unit #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic signed [DATA_WIDTH-1:0]         req_data_in,
   input  logic [mpq_pkg::LVL_W-1:0]            req_priority_req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [DATA_WIDTH-1:0]         rsp_data_out,
   output logic [mpq_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_queue_empty,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mpq_pkg::LVL_W-1:0]            csr_highest_level
);

   import mpq_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic                     op_ff, op_in;
   logic [DATA_WIDTH-1:0]    data_ff, data_in_r;
   logic [LVL_W-1:0]         lvl_ff, lvl_in;
   logic [IW-1:0]            node_ff, node_in;
   logic                     avail_ff, avail_in;
   logic [LVL_W-1:0]         highest_ff, highest_in;
   logic [IW-1:0]            heads_ff [LEVELS];
   logic [IW-1:0]            heads_in [LEVELS];
   logic [IW-1:0]            tails_ff [LEVELS];
   logic [IW-1:0]            tails_in [LEVELS];
   level_mask_type           nonempty_ff, nonempty_in;
   logic [IW-1:0]            rec_head_ff, rec_head_in;
   logic [CW-1:0]            rec_count_ff, rec_count_in;
   logic [CW-1:0]            fresh_ff, fresh_in;
   logic [CW-1:0]            free_count_ff, free_count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   level_mask_type           scan_mask;
   level_mask_type           avail_now;
   logic [LVL_W-1:0]         deq_lvl;
   logic                     accept;
   logic                     out_free;
   logic                     finish;

   logic                     val_wr_en;
   logic                     link_wr_en;
   logic [IW-1:0]            link_wr_addr;
   logic [IW-1:0]            link_wr_data;
   logic                     val_rd_en;
   logic [IW-1:0]            link_rd_addr;
   logic [DATA_WIDTH-1:0]    val_rd_data;
   logic [IW-1:0]            link_rd_data;

   mpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_values (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (node_ff),
      .wr_data (data_ff),
      .rd_en   (val_rd_en),
      .rd_addr (heads_ff[deq_lvl]),
      .rd_data (val_rd_data)
   );

   mpq_ram #(
      .WIDTH (IW),
      .DEPTH (CAPACITY)
   ) u_links (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (accept),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         scan_mask[i] = (LVL_W'(i) <= highest_ff);
      end
      avail_now = nonempty_ff & scan_mask;
      deq_lvl   = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (avail_now[i]) begin
            deq_lvl = LVL_W'(i);
         end
      end
   end

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_FINISH) && out_free;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign val_rd_en    = accept && (req_operation == OP_DEQUEUE);
   assign link_rd_addr = (req_operation == OP_DEQUEUE) ? heads_ff[deq_lvl] : rec_head_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      data_in_r     = data_ff;
      lvl_in        = lvl_ff;
      node_in       = node_ff;
      avail_in      = avail_ff;
      highest_in    = highest_ff;
      heads_in      = heads_ff;
      tails_in      = tails_ff;
      nonempty_in   = nonempty_ff;
      rec_head_in   = rec_head_ff;
      rec_count_in  = rec_count_ff;
      fresh_in      = fresh_ff;
      free_count_in = free_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      val_wr_en     = 1'b0;
      link_wr_en    = 1'b0;
      link_wr_addr  = node_ff;
      link_wr_data  = rec_head_ff;

      if (csr_valid) begin
         highest_in = csr_highest_level;
      end

      if (accept) begin
         state_in  = ST_FINISH;
         op_in     = req_operation;
         data_in_r = req_data_in;
         avail_in  = |avail_now;
         if (req_operation == OP_DEQUEUE) begin
            lvl_in  = deq_lvl;
            node_in = heads_ff[deq_lvl];
         end else begin
            lvl_in  = req_priority_req;
            node_in = (rec_count_ff != '0) ? rec_head_ff : fresh_ff[IW-1:0];
         end
      end

      if (finish) begin
         state_in      = ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = STATUS_OK;
         if (op_ff == OP_ENQUEUE) begin
            if (lvl_ff > highest_ff) begin
               rsp_status_in = STATUS_RANGE;
            end else if (free_count_ff == '0) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               val_wr_en = 1'b1;
               if (nonempty_ff[lvl_ff]) begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = tails_ff[lvl_ff];
                  link_wr_data = node_ff;
               end else begin
                  heads_in[lvl_ff] = node_ff;
               end
               tails_in[lvl_ff]    = node_ff;
               nonempty_in[lvl_ff] = 1'b1;
               free_count_in       = free_count_ff - 1'b1;
               if (rec_count_ff != '0) begin
                  rec_head_in  = link_rd_data;
                  rec_count_in = rec_count_ff - 1'b1;
               end else begin
                  fresh_in = fresh_ff + 1'b1;
               end
            end
         end else begin
            if (!avail_ff) begin
               rsp_data_in   = '1;
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_data_in = val_rd_data;
               if (node_ff == tails_ff[lvl_ff]) begin
                  nonempty_in[lvl_ff] = 1'b0;
               end else begin
                  heads_in[lvl_ff] = link_rd_data;
               end
               link_wr_en    = 1'b1;
               link_wr_addr  = node_ff;
               link_wr_data  = rec_head_ff;
               rec_head_in   = node_ff;
               rec_count_in  = rec_count_ff + 1'b1;
               free_count_in = free_count_ff + 1'b1;
            end
         end
         rsp_empty_in = ~|(nonempty_in & scan_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         highest_ff    <= LVL_W'(7);
         nonempty_ff   <= '0;
         rec_head_ff   <= '0;
         rec_count_ff  <= '0;
         fresh_ff      <= '0;
         free_count_ff <= CAP_C;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            heads_ff[i] <= '0;
            tails_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         highest_ff    <= highest_in;
         nonempty_ff   <= nonempty_in;
         rec_head_ff   <= rec_head_in;
         rec_count_ff  <= rec_count_in;
         fresh_ff      <= fresh_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         heads_ff      <= heads_in;
         tails_ff      <= tails_in;
      end
      op_ff         <= op_in;
      data_ff       <= data_in_r;
      lvl_ff        <= lvl_in;
      node_ff       <= node_in;
      avail_ff      <= avail_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_empty = rsp_empty_ff;

   // free nodes = recycled nodes + never-used nodes
   a_free_split: assert property (@(posedge clock) disable iff (reset)
      free_count_ff == CW'(rec_count_ff + (CAP_C - fresh_ff)))
      else $error("free count out of step with recycle list and fresh counter");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CAP_C)
      else $error("free count above capacity");

   a_deq_frees: assert property (@(posedge clock) disable iff (reset)
      finish && (op_ff == OP_DEQUEUE) && avail_ff
      |=> free_count_ff == CW'($past(free_count_ff) + 1'b1))
      else $error("dequeue did not return its node");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      finish && (op_ff == OP_DEQUEUE) && !avail_ff
      |=> (rsp_status_ff == STATUS_EMPTY) && (rsp_data_ff == '1))
      else $error("empty dequeue result wrong");

   a_enq_takes: assert property (@(posedge clock) disable iff (reset)
      finish && (op_ff == OP_ENQUEUE) && (lvl_ff <= highest_ff) && (free_count_ff != '0)
      |=> nonempty_ff[$past(lvl_ff)] && (rsp_status_ff == STATUS_OK))
      else $error("accepted enqueue left its level empty");

endmodule

// ===== tb/tb_multilevel_priority_queue_unit.sv =====
// Testbench for multilevel_priority_queue_unit: directed table, then random
// enqueue/dequeue traffic in fill, mixed and drain phases, checked against a predictor.
// Depends on mpq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_multilevel_priority_queue_unit;
   import mpq_pkg::*;

   localparam int NODES          = 64;
   localparam int DATA_W         = 32;
   localparam int RANDOM_ITEMS   = 950;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic                empty;
   } queue_result_type;

   typedef enum logic { ROW_ITEM, ROW_LEVEL } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic              op;
      logic [DATA_W-1:0] value;
      logic [LVL_W-1:0]  lvl;
      queue_result_type  want;
   } stim_row_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic                 req_operation     = OP_ENQUEUE;
   logic [DATA_W-1:0]    req_data_in       = '0;
   logic [LVL_W-1:0]     req_priority_req  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [DATA_W-1:0]    rsp_data_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_queue_empty;
   logic                 csr_valid         = 1'b0;
   logic                 csr_ready;
   logic [LVL_W-1:0]     csr_highest_level = '0;

   // table override travels with the payload
   logic                 row_typed = 1'b0;
   queue_result_type     row_want;

   // predictor state
   logic [DATA_W-1:0]    node_value [NODES];
   logic [5:0]           node_link  [NODES];
   logic [5:0]           level_head [LEVELS];
   logic [5:0]           level_tail [LEVELS];
   level_mask_type       level_busy;
   logic [5:0]           free_ptr;
   int                   free_nodes;
   logic [LVL_W-1:0]     top_cfg;

   queue_result_type     pending_results[$];
   stim_row_type         directed_rows[$];
   int                   mismatches  = 0;
   int                   idle_cycles = 0;
   int                   burst_left  = 0;
   stall_mode_type       stall_mode  = STALL_NONE;
   int                   stall_left  = 0;

   multilevel_priority_queue_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_data_in       (req_data_in),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_queue_empty   (rsp_queue_empty),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_highest_level (csr_highest_level)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void clear_queue_model();
      for (int i = 0; i < NODES; i++) begin
         node_value[i] = '0;
         node_link[i]  = 6'((i + 1) % NODES);
      end
      for (int i = 0; i < LEVELS; i++) begin
         level_head[i] = '0;
         level_tail[i] = '0;
      end
      level_busy = '0;
      free_ptr   = '0;
      free_nodes = NODES;
      top_cfg    = 3'd7;
   endfunction

   function automatic queue_result_type apply_operation(input logic op,
                                                        input logic [DATA_W-1:0] value,
                                                        input logic [LVL_W-1:0] lvl);
      queue_result_type r;
      level_mask_type   scan;
      level_mask_type   avail;
      logic [5:0]       node;
      int               pick;
      r.data   = '0;
      r.status = STATUS_OK;
      scan     = {LEVELS{1'b1}} >> (LEVELS - 1 - int'(top_cfg));
      if (op == OP_ENQUEUE) begin
         if (lvl > top_cfg) begin
            r.status = STATUS_RANGE;
         end else if (free_nodes == 0) begin
            r.status = STATUS_FULL;
         end else begin
            node             = free_ptr;
            free_ptr         = node_link[node];
            free_nodes       = free_nodes - 1;
            node_value[node] = value;
            if (level_busy[lvl]) begin
               node_link[level_tail[lvl]] = node;
            end else begin
               level_head[lvl] = node;
            end
            level_tail[lvl] = node;
            level_busy[lvl] = 1'b1;
         end
      end else begin
         avail = level_busy & scan;
         if (avail == '0) begin
            r.data   = '1;
            r.status = STATUS_EMPTY;
         end else begin
            pick = 0;
            while (!avail[pick]) pick++;
            node   = level_head[pick];
            r.data = node_value[node];
            if (node == level_tail[pick]) begin
               level_busy[pick] = 1'b0;
            end else begin
               level_head[pick] = node_link[node];
            end
            node_link[node] = free_ptr;
            free_ptr        = node;
            free_nodes      = free_nodes + 1;
         end
      end
      r.empty = ((level_busy & scan) == '0);
      return r;
   endfunction

   // transfer monitor, scoreboard and watchdog
   always @(posedge clock) begin
      queue_result_type got;
      queue_result_type want;
      logic             moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved      = 1'b1;
            got.data   = rsp_data_out;
            got.status = rsp_status;
            got.empty  = rsp_queue_empty;
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer: data_out %0d status %0d queue_empty %0b",
                      $signed(got.data), got.status, got.empty);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (got.data !== want.data) begin
                  $error("data_out: expected %0d, got %0d", $signed(want.data),
                         $signed(got.data));
                  mismatches++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.empty !== want.empty) begin
                  $error("queue_empty: expected %0b, got %0b", want.empty, got.empty);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            moved   = 1'b1;
            top_cfg = csr_highest_level;
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want  = apply_operation(req_operation, req_data_in, req_priority_req);
            pending_results.push_back(row_typed ? row_want : want);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver back-pressure, switching between patterns
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_left % 7) < 3);
      endcase
   end

   task automatic send_item(input logic op, input logic [DATA_W-1:0] value,
                            input logic [LVL_W-1:0] lvl, input logic typed,
                            input queue_result_type want);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_data_in      <= value;
      req_priority_req <= lvl;
      row_typed        <= typed;
      row_want         <= want;
      do @(posedge clock); while (req_stall);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_highest(input logic [LVL_W-1:0] lvl);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_highest_level <= lvl;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(input logic op, input logic [DATA_W-1:0] value,
                          input logic [LVL_W-1:0] lvl, input logic [DATA_W-1:0] data,
                          input logic [STATUS_W-1:0] status, input logic empty);
      stim_row_type row;
      row.kind        = ROW_ITEM;
      row.op          = op;
      row.value       = value;
      row.lvl         = lvl;
      row.want.data   = data;
      row.want.status = status;
      row.want.empty  = empty;
      directed_rows.push_back(row);
   endtask

   task automatic add_level_row(input logic [LVL_W-1:0] lvl);
      stim_row_type row;
      row.kind = ROW_LEVEL;
      row.op   = OP_ENQUEUE;
      row.lvl  = lvl;
      directed_rows.push_back(row);
   endtask

   initial begin
      queue_result_type none;
      stim_row_type     row;
      int               random_items;
      int               phase;
      int               phase_len;
      int               enq_pct;
      logic [LVL_W-1:0] lvl_cfg;
      logic             op;
      logic [LVL_W-1:0] pr;

      none.data   = '0;
      none.status = STATUS_OK;
      none.empty  = 1'b0;
      row_want    = none;
      clear_queue_model();

      // FIFO order within a level, level 0 first, data extremes
      add_row(OP_DEQUEUE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, STATUS_EMPTY, 1'b1);
      add_row(OP_ENQUEUE, 32'h7FFF_FFFF, 3'd7, '0, STATUS_OK, 1'b0);
      add_row(OP_ENQUEUE, 32'h8000_0000, 3'd0, '0, STATUS_OK, 1'b0);
      add_row(OP_ENQUEUE, 32'h0000_0000, 3'd0, '0, STATUS_OK, 1'b0);
      add_row(OP_ENQUEUE, 32'hFFFF_FFFF, 3'd3, '0, STATUS_OK, 1'b0);
      add_row(OP_ENQUEUE, 32'h0000_0001, 3'd7, '0, STATUS_OK, 1'b0);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'h8000_0000, STATUS_OK, 1'b0);
      add_row(OP_DEQUEUE, 32'h1234_5678, 3'd5, 32'h0000_0000, STATUS_OK, 1'b0);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, STATUS_OK, 1'b0);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'h7FFF_FFFF, STATUS_OK, 1'b0);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'h0000_0001, STATUS_OK, 1'b1);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, STATUS_EMPTY, 1'b1);
      // level out of range, hidden levels above the register
      add_level_row(3'd2);
      add_row(OP_ENQUEUE, 32'hDEAD_BEEF, 3'd5, '0, STATUS_RANGE, 1'b1);
      add_row(OP_ENQUEUE, 32'hDEAD_BEEF, 3'd3, '0, STATUS_RANGE, 1'b1);
      add_row(OP_ENQUEUE, 32'h0F0F_0F0F, 3'd2, '0, STATUS_OK, 1'b0);
      add_level_row(3'd1);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, STATUS_EMPTY, 1'b1);
      add_row(OP_ENQUEUE, 32'h5A5A_5A5A, 3'd1, '0, STATUS_OK, 1'b0);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'h5A5A_5A5A, STATUS_OK, 1'b1);
      add_level_row(3'd7);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'h0F0F_0F0F, STATUS_OK, 1'b1);
      add_level_row(3'd0);
      add_row(OP_ENQUEUE, 32'h1234_5678, 3'd0, '0, STATUS_OK, 1'b0);
      add_row(OP_ENQUEUE, 32'hA5A5_A5A5, 3'd1, '0, STATUS_RANGE, 1'b0);
      add_row(OP_DEQUEUE, 32'h0000_0000, 3'd0, 32'h1234_5678, STATUS_OK, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_LEVEL) begin
            write_highest(row.lvl);
         end else begin
            send_item(row.op, row.value, row.lvl, 1'b1, row.want);
         end
      end

      // alternate fill, mixed and drain phases, each under its own register value
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0:       lvl_cfg = 3'd7;
            1:       lvl_cfg = 3'd0;
            default: lvl_cfg = 3'($urandom_range(0, 7));
         endcase
         write_highest(lvl_cfg);
         enq_pct   = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 50 : 20;
         phase_len = (phase % 3 == 0) ? $urandom_range(100, 160) : $urandom_range(40, 100);
         if (phase_len > RANDOM_ITEMS - random_items) begin
            phase_len = RANDOM_ITEMS - random_items;
         end
         repeat (phase_len) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            pr = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, lvl_cfg))
                                              : 3'($urandom_range(0, 7));
            send_item(op, $urandom, pr, 1'b0, none);
            random_items++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== multilevel_priority_queue_unit.f =====
src/mpq_pkg.sv
src/mpq_ram.sv
src/multilevel_priority_queue_unit.sv
tb/tb_multilevel_priority_queue_unit.sv
